>>> hw/rtl/assert_macros.svh
// Assertion helpers used by the whitelist table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define ASSERT_SAME_CYCLE(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT_CYCLE(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/uwt_pkg.sv
`default_nettype none

package uwt_pkg;

   // Longest UID the table keeps, in bytes
   localparam int MaxUidBytes = 10;
   localparam logic [7:0] ByteMask = 8'hFF;

   // Request actions
   localparam logic [1:0] ActPresent = 2'd0;
   localparam logic [1:0] ActArm     = 2'd1;
   localparam logic [1:0] ActDelete  = 2'd2;

   // Response status codes
   localparam logic [1:0] StAuth   = 2'd0;
   localparam logic [1:0] StReject = 2'd1;
   localparam logic [1:0] StNew    = 2'd2;

   typedef struct packed {
      logic [1:0]  action;
      logic [3:0]  uid_len;
      logic [63:0] uid_low;
      logic [15:0] uid_high;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        stored;
      logic [3:0]  out_uid_length;
      logic [63:0] out_uid_low;
      logic [15:0] out_uid_high;
   } rsp_type;

   // One table slot as kept in the slot memory
   typedef struct packed {
      logic [3:0]  length;
      logic [63:0] bytes_low;
      logic [15:0] bytes_high;
   } slot_type;

   // Keep bytes 0..7 that lie inside the length
   function automatic logic [63:0] mask_low(input logic [3:0] len);
      logic [63:0] m;
      m = '0;
      for (int i = 0; i < 8; i++) begin
         if (len > 4'(i)) begin
            m[i*8 +: 8] = ByteMask;
         end
      end
      return m;
   endfunction

   // Keep bytes 8 and 9 that lie inside the length
   function automatic logic [15:0] mask_high(input logic [3:0] len);
      logic [15:0] m;
      m = '0;
      for (int i = 0; i < 2; i++) begin
         if (len > 4'(8 + i)) begin
            m[i*8 +: 8] = ByteMask;
         end
      end
      return m;
   endfunction

   function automatic logic length_ok(input logic [3:0] len);
      return (len != 4'd0) && (len <= 4'(MaxUidBytes));
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/uid_whitelist_table.sv
`default_nettype none

// UID whitelist: up to TABLE_ENTRIES card UIDs of 1 to 10 bytes, kept in a slot memory
// with one valid flop per slot (the table is empty after reset, no clearing pass).
// A present request answers authenticated or rejected; after an arm request the next
// present request of an unknown UID stores it in the lowest free slot and answers
// "new" (stored low when the table is full), while a known UID then gives no response.
// A delete request drops an exact match. Arm requests and requests with action 3 or
// a length of 0 or above 10 finish in the cycle they are taken. A present or delete
// request reads every slot through the single memory read port, one slot per cycle,
// and the block takes its next request after S_SCAN, S_LAST and S_FINISH, later if the
// response register is still held by rsp_stall. Bytes above the length are masked.
module uid_whitelist_table #(
   parameter int TABLE_ENTRIES = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire uwt_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output uwt_pkg::rsp_type      rsp_data
);

   import uwt_pkg::*;

`include "assert_macros.svh"

   localparam int IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_ENTRIES - 1);

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_LAST, S_FINISH} state_type;

   state_type              state_ff,    state_in;
   logic [IdxW-1:0]        scan_ff,     scan_in;
   logic                   cmp_vld_ff,  cmp_vld_in;
   logic [IdxW-1:0]        cmp_idx_ff,  cmp_idx_in;
   logic                   del_ff,      del_in;
   slot_type               key_ff,      key_in;
   logic                   hit_ff,      hit_in;
   logic [IdxW-1:0]        hit_idx_ff,  hit_idx_in;
   logic                   free_ff,     free_in;
   logic [IdxW-1:0]        free_idx_ff, free_idx_in;
   logic                   armed_ff,    armed_in;
   logic [TABLE_ENTRIES-1:0] valid_ff,  valid_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff,  rsp_data_in;

   logic     accept;
   logic     finish_go;
   logic     wr_en;
   logic     emit;
   logic     slot_hit;
   logic     slot_free;
   slot_type rd_slot;

   // Slot memory: scanned through the read port, written on registration
   uwt_ram #(
      .Width ($bits(slot_type)),
      .Depth (TABLE_ENTRIES)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (free_idx_ff),
      .wr_data (key_ff),
      .rd_addr (scan_ff),
      .rd_data (rd_slot)
   );

   // Handshake and finish conditions
   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign finish_go = (state_ff == S_FINISH) && (!rsp_valid_ff || !rsp_stall);
   assign wr_en     = finish_go && !del_ff && armed_ff && !hit_ff && free_ff;
   assign emit      = finish_go && !del_ff && (!armed_ff || !hit_ff);

   // Compare the slot read in the previous cycle
   assign slot_hit  = cmp_vld_ff && valid_ff[cmp_idx_ff] && (rd_slot == key_ff);
   assign slot_free = cmp_vld_ff && !valid_ff[cmp_idx_ff];

   always_comb begin
      state_in    = state_ff;
      scan_in     = scan_ff;
      cmp_vld_in  = 1'b0;
      cmp_idx_in  = scan_ff;
      del_in      = del_ff;
      key_in      = key_ff;
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      free_in     = free_ff;
      free_idx_in = free_idx_ff;
      armed_in    = armed_ff;
      valid_in    = valid_ff;

      // Sequence one request
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_data.action)
                  ActArm: begin
                     armed_in = 1'b1;
                  end
                  ActPresent, ActDelete: begin
                     if (length_ok(req_data.uid_len)) begin
                        key_in.length     = req_data.uid_len;
                        key_in.bytes_low  = req_data.uid_low & mask_low(req_data.uid_len);
                        key_in.bytes_high = req_data.uid_high & mask_high(req_data.uid_len);
                        del_in   = (req_data.action == ActDelete);
                        hit_in   = 1'b0;
                        free_in  = 1'b0;
                        scan_in  = '0;
                        state_in = S_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SCAN: begin
            cmp_vld_in = 1'b1;
            if (scan_ff == LastIdx) begin
               state_in = S_LAST;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         S_LAST: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (finish_go) begin
               state_in = S_IDLE;
               if (del_ff && hit_ff) begin
                  valid_in[hit_idx_ff] = 1'b0;
               end
               if (!del_ff) begin
                  armed_in = 1'b0;
               end
               if (wr_en) begin
                  valid_in[free_idx_ff] = 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Record the first match and the lowest free slot
      if (slot_hit && !hit_ff) begin
         hit_in     = 1'b1;
         hit_idx_in = cmp_idx_ff;
      end
      if (slot_free && !free_ff) begin
         free_in     = 1'b1;
         free_idx_in = cmp_idx_ff;
      end

      // Load the response register or drop a taken response
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (emit) begin
         rsp_valid_in               = 1'b1;
         rsp_data_in.status         = armed_ff ? StNew : (hit_ff ? StAuth : StReject);
         rsp_data_in.stored         = wr_en;
         rsp_data_in.out_uid_length = key_ff.length;
         rsp_data_in.out_uid_low    = key_ff.bytes_low;
         rsp_data_in.out_uid_high   = key_ff.bytes_high;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cmp_vld_ff   <= 1'b0;
         armed_ff     <= 1'b0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cmp_vld_ff   <= cmp_vld_in;
         armed_ff     <= armed_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      scan_ff     <= scan_in;
      cmp_idx_ff  <= cmp_idx_in;
      del_ff      <= del_in;
      key_ff      <= key_in;
      hit_ff      <= hit_in;
      hit_idx_ff  <= hit_idx_in;
      free_ff     <= free_in;
      free_idx_ff <= free_idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A stored flag only comes with a new-UID response
   `ASSERT_SAME_CYCLE(a_stored_is_new, clock, reset, rsp_valid && rsp_data.stored, rsp_data.status == StNew, "stored response without new status")

   // A registration write adds exactly one slot
   `ASSERT_NEXT_CYCLE(a_write_grows, clock, reset, wr_en, $countones(valid_ff) == $past($countones(valid_ff)) + 1, "registration did not add one slot")

   // A recorded match points at a listed slot
   `ASSERT_SAME_CYCLE(a_hit_listed, clock, reset, (state_ff == S_FINISH) && hit_ff, valid_ff[hit_idx_ff], "match recorded on an empty slot")

   // No compare is pending while requests are taken
   `ASSERT_SAME_CYCLE(a_idle_quiet, clock, reset, !req_stall, !cmp_vld_ff, "slot compare pending in idle")

endmodule

`default_nettype wire

>>> hw/rtl/uwt_ram.sv
`default_nettype none

module uwt_ram #(
   parameter int Width = 8,
   parameter int Depth = 16,
   localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AddrW-1:0] wr_addr,
   input  wire logic [Width-1:0] wr_data,
   input  wire logic [AddrW-1:0] rd_addr,
   output logic      [Width-1:0] rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   // Write one word, read one word with registered data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> bench/tb_uid_whitelist_table.sv
`timescale 1ns / 100ps

module tb_uid_whitelist_table;
   import uwt_pkg::*;

   localparam int TableEntries = 16;
   localparam int PoolSize = 24;
   localparam int RandomItems = 1875;
   localparam int HoldStart = 3000;
   localparam int HoldCycles = 500;
   localparam int DrainCycles = 3 * (TableEntries + 3);
   localparam logic [1:0] ActUnused = 2'd3;
   localparam logic [63:0] AllLow = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [15:0] AllHigh = 16'hFFFF;

   typedef enum int {RxFlow, RxCoin, RxHeavy, RxPeriodic} rx_mode_type;

   // Tracks the table contents and the answers still owed by the block
   class whitelist_sb_type;
      logic        slot_valid [TableEntries];
      logic [3:0]  slot_len [TableEntries];
      logic [63:0] slot_low [TableEntries];
      logic [15:0] slot_high [TableEntries];
      logic        armed;
      rsp_type     due_answers[$];
      int errors, n_auth, n_reject, n_new_stored, n_new_full;
      int n_known_silent, n_dropped, n_arm, n_ignored;

      function new();
         int i;
         for (i = 0; i < TableEntries; i++) begin
            slot_valid[i] = 1'b0;
         end
         armed = 1'b0;
         errors = 0;
         n_auth = 0;
         n_reject = 0;
         n_new_stored = 0;
         n_new_full = 0;
         n_known_silent = 0;
         n_dropped = 0;
         n_arm = 0;
         n_ignored = 0;
      endfunction

      function logic [63:0] low_keep(logic [3:0] len);
         int n;
         n = len;
         if (n >= 8) begin
            return AllLow;
         end
         return (64'd1 << (8 * n)) - 64'd1;
      endfunction

      function logic [15:0] high_keep(logic [3:0] len);
         if (len >= 4'd10) begin
            return AllHigh;
         end
         return (len == 4'd9) ? 16'h00FF : 16'h0000;
      endfunction

      function void flag(string what);
         errors++;
         if (errors <= 10) begin
            $display("[%0t] %s", $time, what);
         end
      endfunction

      // Apply one accepted request to the table copy and queue its answer
      function void note_request(req_type r);
         logic [63:0] lo;
         logic [15:0] hi;
         int          hit;
         int          free_slot;
         int          i;
         rsp_type     e;
         if (r.action == ActArm) begin
            armed = 1'b1;
            n_arm++;
            return;
         end
         if (r.action == ActUnused || r.uid_len == 4'd0 || r.uid_len > MaxUidBytes) begin
            n_ignored++;
            return;
         end
         lo = r.uid_low & low_keep(r.uid_len);
         hi = r.uid_high & high_keep(r.uid_len);
         hit = -1;
         for (i = TableEntries - 1; i >= 0; i--) begin
            if (slot_valid[i] && slot_len[i] == r.uid_len && slot_low[i] == lo &&
                slot_high[i] == hi) begin
               hit = i;
            end
         end
         if (r.action == ActDelete) begin
            if (hit >= 0) begin
               slot_valid[hit] = 1'b0;
               n_dropped++;
            end
            return;
         end
         e.stored = 1'b0;
         e.out_uid_length = r.uid_len;
         e.out_uid_low = lo;
         e.out_uid_high = hi;
         if (!armed) begin
            e.status = (hit >= 0) ? StAuth : StReject;
            if (hit >= 0) n_auth++;
            else n_reject++;
            due_answers.push_back(e);
            return;
         end
         // registration mode lasts for one present request only
         armed = 1'b0;
         if (hit >= 0) begin
            n_known_silent++;
            return;
         end
         free_slot = -1;
         for (i = TableEntries - 1; i >= 0; i--) begin
            if (!slot_valid[i]) free_slot = i;
         end
         if (free_slot >= 0) begin
            slot_valid[free_slot] = 1'b1;
            slot_len[free_slot] = r.uid_len;
            slot_low[free_slot] = lo;
            slot_high[free_slot] = hi;
            e.stored = 1'b1;
            n_new_stored++;
         end else begin
            n_new_full++;
         end
         e.status = StNew;
         due_answers.push_back(e);
      endfunction

      // Compare one answer with the oldest one owed
      function void check_answer(rsp_type got);
         rsp_type want;
         if (due_answers.size() == 0) begin
            flag($sformatf("unexpected answer: status %0d stored %0d len %0d uid %h_%h",
                           got.status, got.stored, got.out_uid_length, got.out_uid_high,
                           got.out_uid_low));
            return;
         end
         want = due_answers.pop_front();
         if (got.status !== want.status || got.stored !== want.stored ||
             got.out_uid_length !== want.out_uid_length ||
             got.out_uid_low !== want.out_uid_low || got.out_uid_high !== want.out_uid_high) begin
            flag($sformatf({"answer mismatch: expected st %0d stored %0d len %0d uid %h_%h,",
                            " got st %0d stored %0d len %0d uid %h_%h"},
                           want.status, want.stored, want.out_uid_length, want.out_uid_high,
                           want.out_uid_low, got.status, got.stored, got.out_uid_length,
                           got.out_uid_high, got.out_uid_low));
         end
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   req_type req_data = '0;
   logic    rsp_stall = 1'b0;
   logic    req_stall;
   logic    rsp_valid;
   rsp_type rsp_data;

   whitelist_sb_type sb = new();

   logic [3:0]  pool_len [PoolSize];
   logic [63:0] pool_low [PoolSize];
   logic [15:0] pool_high [PoolSize];
   int          burst_left = 0;
   int          n_sent = 0;

   uid_whitelist_table #(.TABLE_ENTRIES(TableEntries)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   always #2 clock = ~clock;

   // Build a request; with junk set, bytes above the length get fresh random bits
   function automatic req_type make_req(logic [1:0] act, logic [3:0] len, logic [63:0] lo,
                                        logic [15:0] hi, bit junk);
      req_type     r;
      logic [63:0] ml;
      logic [15:0] mh;
      logic [63:0] noise_low;
      logic [15:0] noise_high;
      ml = sb.low_keep(len);
      mh = sb.high_keep(len);
      noise_low = {$urandom, $urandom};
      noise_high = 16'($urandom);
      r.action = act;
      r.uid_len = len;
      r.uid_low = junk ? ((lo & ml) | (noise_low & ~ml)) : lo;
      r.uid_high = junk ? ((hi & mh) | (noise_high & ~mh)) : hi;
      return r;
   endfunction

   // Choose a UID: one now in the table, a fresh random one, or one from the pool
   function automatic void pick_uid(input int listed_pct, input int fresh_pct,
                                    output logic [3:0] len, output logic [63:0] lo,
                                    output logic [15:0] hi);
      int roll;
      int i;
      int idx;
      int listed[$];
      roll = $urandom_range(0, 99);
      for (i = 0; i < TableEntries; i++) begin
         if (sb.slot_valid[i]) listed.push_back(i);
      end
      if (roll < listed_pct && listed.size() > 0) begin
         idx = listed[$urandom_range(0, listed.size() - 1)];
         len = sb.slot_len[idx];
         lo = sb.slot_low[idx];
         hi = sb.slot_high[idx];
      end else if (roll < listed_pct + fresh_pct) begin
         len = 4'($urandom_range(1, MaxUidBytes));
         lo = {$urandom, $urandom};
         hi = 16'($urandom);
      end else begin
         idx = $urandom_range(0, PoolSize - 1);
         len = pool_len[idx];
         lo = pool_low[idx];
         hi = pool_high[idx];
      end
   endfunction

   // Offer one request, hold it until taken, then maybe idle between bursts
   task automatic send_request(input req_type r);
      int gap;
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(r);
      n_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(0, 24);
      end
   endtask

   task automatic directed_phase();
      send_request(make_req(ActPresent, 4'd1, 64'd0, 16'd0, 0));
      send_request(make_req(ActArm, 4'd0, 64'd0, 16'd0, 0));
      send_request(make_req(ActPresent, 4'd10, AllLow, AllHigh, 0));
      send_request(make_req(ActPresent, 4'd10, AllLow, AllHigh, 0));
      // known UID while armed: silent, mode drops back
      send_request(make_req(ActArm, 4'd15, AllLow, AllHigh, 0));
      send_request(make_req(ActPresent, 4'd10, AllLow, AllHigh, 0));
      send_request(make_req(ActPresent, 4'd10, AllLow, AllHigh, 0));
      // bad lengths and the unused action do nothing
      send_request(make_req(ActPresent, 4'd0, AllLow, AllHigh, 0));
      send_request(make_req(ActPresent, 4'd11, AllLow, AllHigh, 0));
      send_request(make_req(ActDelete, 4'd15, AllLow, AllHigh, 0));
      send_request(make_req(ActUnused, 4'd10, AllLow, AllHigh, 0));
      send_request(make_req(ActPresent, 4'd10, AllLow, AllHigh, 0));
      // arming twice, bytes above the length must be masked
      send_request(make_req(ActArm, 4'd0, 64'd0, 16'd0, 0));
      send_request(make_req(ActArm, 4'd0, 64'd0, 16'd0, 0));
      send_request(make_req(ActPresent, 4'd1, 64'hFFFF_FFFF_FFFF_FF5A, AllHigh, 0));
      send_request(make_req(ActPresent, 4'd1, 64'h0123_4567_89AB_CD5A, 16'h1234, 0));
      send_request(make_req(ActPresent, 4'd2, 64'h0000_0000_0000_005A, 16'd0, 0));
      // delete miss, then a hit
      send_request(make_req(ActDelete, 4'd2, 64'h0000_0000_0000_005A, 16'd0, 0));
      send_request(make_req(ActDelete, 4'd10, AllLow, AllHigh, 0));
      send_request(make_req(ActPresent, 4'd10, AllLow, AllHigh, 0));
      // a bad length keeps registration mode armed
      send_request(make_req(ActArm, 4'd0, 64'd0, 16'd0, 0));
      send_request(make_req(ActPresent, 4'd12, AllLow, AllHigh, 0));
      send_request(make_req(ActPresent, 4'd9, AllLow, 16'h3C77, 0));
      send_request(make_req(ActPresent, 4'd8, AllLow, 16'd0, 0));
      send_request(make_req(ActPresent, 4'd9, AllLow, 16'hA577, 0));
   endtask

   task automatic random_phase();
      int          counted;
      int          pick;
      logic [3:0]  len;
      logic [63:0] lo;
      logic [15:0] hi;
      logic [1:0]  act;
      counted = 0;
      while (counted < RandomItems) begin
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            pick_uid(15, 15, len, lo, hi);
            send_request(make_req(ActPresent, len, lo, hi, 1'($urandom_range(0, 1))));
            counted++;
         end else if (pick < 63) begin
            // registration: arm, then present a UID
            send_request(make_req(ActArm, 4'($urandom), {$urandom, $urandom},
                                  16'($urandom), 0));
            pick_uid(5, 10, len, lo, hi);
            send_request(make_req(ActPresent, len, lo, hi, 1'($urandom_range(0, 1))));
            counted += 2;
         end else if (pick < 78) begin
            pick_uid(50, 5, len, lo, hi);
            send_request(make_req(ActDelete, len, lo, hi, 1'($urandom_range(0, 1))));
            counted++;
         end else begin
            case ($urandom_range(0, 4))
               0: begin
                  len = ($urandom_range(0, 1) == 1) ? 4'd0 : 4'($urandom_range(11, 15));
                  act = ($urandom_range(0, 1) == 1) ? ActPresent : ActDelete;
                  send_request(make_req(act, len, {$urandom, $urandom}, 16'($urandom), 0));
                  counted++;
               end
               1: begin
                  send_request(make_req(ActUnused, 4'($urandom), {$urandom, $urandom},
                                        16'($urandom), 0));
                  counted++;
               end
               2: begin
                  send_request(make_req(ActArm, 4'($urandom), {$urandom, $urandom},
                                        16'($urandom), 0));
                  send_request(make_req(ActPresent, 4'($urandom_range(11, 15)),
                                        {$urandom, $urandom}, 16'($urandom), 0));
                  pick_uid(10, 20, len, lo, hi);
                  send_request(make_req(ActPresent, len, lo, hi, 1));
                  counted += 3;
               end
               3: begin
                  send_request(make_req(ActArm, 4'($urandom), {$urandom, $urandom},
                                        16'($urandom), 0));
                  counted++;
               end
               default: begin
                  send_request(make_req(ActPresent, 4'd10, {$urandom, $urandom},
                                        16'($urandom), 0));
                  counted++;
               end
            endcase
         end
      end
   endtask

   // Stimulus and end of run
   initial begin
      int i;
      // every odd pool entry shares its bytes with the one before, one byte shorter (10 after a 1-byte one)
      for (i = 0; i < PoolSize; i++) begin
         pool_len[i] = 4'(1 + (i % MaxUidBytes));
         pool_low[i] = {$urandom, $urandom};
         pool_high[i] = 16'($urandom);
         if (i % 2 == 1 && pool_len[i] > 4'd1) begin
            pool_len[i] = pool_len[i - 1] - 4'd1;
            if (pool_len[i - 1] == 4'd1) pool_len[i] = 4'd10;
            pool_low[i] = pool_low[i - 1];
            pool_high[i] = pool_high[i - 1];
         end
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      directed_phase();
      random_phase();
      req_valid <= 1'b0;
      while (sb.due_answers.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      $display("Run covered %0d requests: %0d authenticated, %0d rejected, %0d stored new,",
               n_sent, sb.n_auth, sb.n_reject, sb.n_new_stored);
      $display("%0d new with table full, %0d known while armed, %0d deletes hit, %0d arms, %0d ignored; %0d errors",
               sb.n_new_full, sb.n_known_silent, sb.n_dropped, sb.n_arm, sb.n_ignored, sb.errors);
      if (sb.errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Receiver: change stall pattern now and then, with one long hold-off
   int          rx_cycle = 0;
   int          hold_left = 0;
   int          mode_left = 0;
   rx_mode_type rx_mode = RxFlow;

   always @(posedge clock) begin
      rx_cycle++;
      if (rx_cycle == HoldStart) hold_left = HoldCycles;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         if (mode_left == 0) begin
            rx_mode = rx_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(32, 256);
         end else begin
            mode_left--;
         end
         case (rx_mode)
            RxFlow:  rsp_stall <= 1'b0;
            RxCoin:  rsp_stall <= ($urandom_range(0, 1) == 1);
            RxHeavy: rsp_stall <= ($urandom_range(0, 4) != 0);
            default: rsp_stall <= ((rx_cycle % 8) >= 4);
         endcase
      end
   end

   // Check each answer the block hands over
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_answer(rsp_data);
      end
   end

   // Hang guard
   initial begin
      #4_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
